// File: rtl/nnps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nnps_pkg
// Shared types and fixed widths for the nearest nonzero pixel search block.
// ----------------------------------------------------------------------------
package nnps_pkg;

	localparam int COORD_BITS     = 8;
	localparam int VALUE_BITS     = 8;
	localparam int CFG_BITS       = 9;
	localparam int CFG_INDEX_BITS = 1;
	localparam int EPOCH_BITS     = 8;

	localparam logic [CFG_BITS-1:0] SIZE_RESET = 9'd256;

	typedef enum logic [0:0] {
		CMD_WRITE = 1'b0,
		CMD_QUERY = 1'b1
	} cmd_t;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_WIDTH  = 1'b0,
		REG_HEIGHT = 1'b1
	} reg_idx_t;

	typedef struct packed {
		cmd_t                  command;
		logic [COORD_BITS-1:0] column;
		logic [COORD_BITS-1:0] row;
		logic [VALUE_BITS-1:0] pixel_value;
	} item_t;

	typedef struct packed {
		logic [CFG_BITS-1:0] image_width;
		logic [CFG_BITS-1:0] image_height;
	} cfg_t;

	typedef struct packed {
		logic                  valid;
		logic [VALUE_BITS-1:0] value;
	} res_t;

endpackage

// File: rtl/nnps_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nnps_if
// Valid/ready channels: input words (writes and queries) and result words.
// ----------------------------------------------------------------------------
interface nnps_in_if;
	logic                             valid;
	logic                             ready;
	logic                             command;
	logic [nnps_pkg::COORD_BITS-1:0]  column;
	logic [nnps_pkg::COORD_BITS-1:0]  row;
	logic [nnps_pkg::VALUE_BITS-1:0]  pixel_value;

	modport source (output valid, command, column, row, pixel_value, input ready);
	modport sink (input valid, command, column, row, pixel_value, output ready);
endinterface

interface nnps_out_if;
	logic                             valid;
	logic                             ready;
	logic [nnps_pkg::VALUE_BITS-1:0]  nearest_value;

	modport source (output valid, nearest_value, input ready);
	modport sink (input valid, nearest_value, output ready);
endinterface

// File: rtl/nnps_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nnps_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module nnps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/nnps_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nnps_engine
// Pixel store, epoch-tagged visited map and coordinate queue, with the
// sequencer that runs the breadth-first search over them.
// ----------------------------------------------------------------------------
module nnps_engine #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256,
	parameter int PIXEL_BITS = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  nnps_pkg::item_t item,
	input  nnps_pkg::cfg_t  cfg,
	output logic            ready,
	input  logic            out_free,
	output nnps_pkg::res_t  res
);

	localparam int CW    = $clog2(MAX_WIDTH);
	localparam int RW    = $clog2(MAX_HEIGHT);
	localparam int AW    = CW + RW;
	localparam int DEPTH = 1 << AW;
	localparam int WW    = CW + 1;
	localparam int HW    = RW + 1;
	localparam int EB    = nnps_pkg::EPOCH_BITS;
	localparam int VB    = nnps_pkg::VALUE_BITS;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_START,
		S_DEQ,
		S_DEQ_WAIT,
		S_PIX,
		S_NB_RD,
		S_NB_WR,
		S_RESULT
	} state_t;

	typedef enum logic [1:0] {
		DIR_RIGHT = 2'd0,
		DIR_DOWN  = 2'd1,
		DIR_LEFT  = 2'd2,
		DIR_UP    = 2'd3
	} dir_t;

	state_t          state_q;
	dir_t            nb_q;
	logic [AW-1:0]   clr_addr_q;
	logic [EB-1:0]   epoch_q;
	logic [CW-1:0]   cur_col_q;
	logic [RW-1:0]   cur_row_q;
	logic [AW:0]     head_q;
	logic [AW:0]     tail_q;
	logic [VB-1:0]   res_value_q;
	logic            wrap_q;

	logic [WW-1:0]   w_eff;
	logic [HW-1:0]   h_eff;
	logic [CW-1:0]   nb_col;
	logic [RW-1:0]   nb_row;
	logic            nb_ok;
	logic [AW-1:0]   nb_addr;
	logic [AW-1:0]   cur_addr;
	logic [AW-1:0]   start_addr;
	logic            query_in_range;
	logic            write_in_range;
	logic            pix_nonzero;
	logic            nb_new;

	logic                  pix_we;
	logic [AW-1:0]         pix_waddr;
	logic [PIXEL_BITS-1:0] pix_wdata;
	logic [AW-1:0]         pix_raddr;
	logic [PIXEL_BITS-1:0] pix_rdata;
	logic                  vis_we;
	logic [AW-1:0]         vis_waddr;
	logic [EB-1:0]         vis_wdata;
	logic [EB-1:0]         vis_rdata;
	logic                  q_we;
	logic [AW-1:0]         q_waddr;
	logic [AW-1:0]         q_wdata;
	logic [AW-1:0]         q_rdata;

	// clamp the size registers to the store
	always_comb begin
		if (32'(cfg.image_width) > 32'(MAX_WIDTH)) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(cfg.image_width);
		end
		if (32'(cfg.image_height) > 32'(MAX_HEIGHT)) begin
			h_eff = HW'(MAX_HEIGHT);
		end else begin
			h_eff = HW'(cfg.image_height);
		end
	end

	assign query_in_range = (32'(item.column) < 32'(w_eff)) && (32'(item.row) < 32'(h_eff));
	assign write_in_range = (32'(item.column) < 32'(MAX_WIDTH)) &&
		(32'(item.row) < 32'(MAX_HEIGHT));
	assign start_addr = {RW'(item.row), CW'(item.column)};
	assign cur_addr   = {cur_row_q, cur_col_q};

	always_comb begin
		nb_col = cur_col_q;
		nb_row = cur_row_q;
		nb_ok  = 1'b0;
		case (nb_q)
			DIR_RIGHT: begin
				nb_ok  = (WW'(cur_col_q) + WW'(1)) < w_eff;
				nb_col = cur_col_q + CW'(1);
			end
			DIR_DOWN: begin
				nb_ok  = (HW'(cur_row_q) + HW'(1)) < h_eff;
				nb_row = cur_row_q + RW'(1);
			end
			DIR_LEFT: begin
				nb_ok  = cur_col_q != '0;
				nb_col = cur_col_q - CW'(1);
			end
			DIR_UP: begin
				nb_ok  = cur_row_q != '0;
				nb_row = cur_row_q - RW'(1);
			end
			default: begin
				nb_ok = 1'b0;
			end
		endcase
	end

	assign nb_addr     = {nb_row, nb_col};
	assign pix_nonzero = pix_rdata != '0;
	assign nb_new      = vis_rdata != epoch_q;

	// pixel store: writes straight from an accepted word
	assign pix_we    = start && ready && (item.command == nnps_pkg::CMD_WRITE) && write_in_range;
	assign pix_waddr = start_addr;
	assign pix_wdata = PIXEL_BITS'(item.pixel_value);
	assign pix_raddr = (state_q == S_DEQ_WAIT) ? q_rdata : start_addr;

	// visited map: an entry is visited when it holds the current epoch
	always_comb begin
		vis_we    = 1'b0;
		vis_waddr = nb_addr;
		vis_wdata = epoch_q;
		q_we      = 1'b0;
		q_waddr   = tail_q[AW-1:0];
		q_wdata   = nb_addr;
		case (state_q)
			S_CLEAR: begin
				vis_we    = 1'b1;
				vis_waddr = clr_addr_q;
				vis_wdata = '0;
			end
			S_START: begin
				vis_we    = !pix_nonzero;
				vis_waddr = cur_addr;
				q_we      = !pix_nonzero;
				q_waddr   = '0;
				q_wdata   = cur_addr;
			end
			S_NB_WR: begin
				vis_we = nb_new;
				q_we   = nb_new;
			end
			default: begin
				vis_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			nb_q        <= DIR_RIGHT;
			clr_addr_q  <= '0;
			epoch_q     <= EB'(1);
			cur_col_q   <= '0;
			cur_row_q   <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			res_value_q <= '0;
			wrap_q      <= 1'b0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					clr_addr_q <= clr_addr_q + AW'(1);
					if (&clr_addr_q) begin
						epoch_q <= EB'(1);
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start && (item.command == nnps_pkg::CMD_QUERY)) begin
						cur_col_q <= CW'(item.column);
						cur_row_q <= RW'(item.row);
						if (query_in_range) begin
							state_q <= S_START;
						end else begin
							res_value_q <= '0;
							wrap_q      <= 1'b0;
							state_q     <= S_RESULT;
						end
					end
				end
				S_START: begin
					if (pix_nonzero) begin
						res_value_q <= VB'(pix_rdata);
						wrap_q      <= 1'b0;
						state_q     <= S_RESULT;
					end else begin
						head_q  <= '0;
						tail_q  <= (AW + 1)'(1);
						state_q <= S_DEQ;
					end
				end
				S_DEQ: begin
					if (head_q == tail_q) begin
						res_value_q <= '0;
						wrap_q      <= &epoch_q;
						epoch_q     <= epoch_q + EB'(1);
						state_q     <= S_RESULT;
					end else begin
						head_q  <= head_q + (AW + 1)'(1);
						state_q <= S_DEQ_WAIT;
					end
				end
				S_DEQ_WAIT: begin
					cur_col_q <= q_rdata[CW-1:0];
					cur_row_q <= q_rdata[AW-1:CW];
					state_q   <= S_PIX;
				end
				S_PIX: begin
					if (pix_nonzero) begin
						res_value_q <= VB'(pix_rdata);
						wrap_q      <= &epoch_q;
						epoch_q     <= epoch_q + EB'(1);
						state_q     <= S_RESULT;
					end else begin
						nb_q    <= DIR_RIGHT;
						state_q <= S_NB_RD;
					end
				end
				S_NB_RD: begin
					if (nb_ok) begin
						state_q <= S_NB_WR;
					end else if (nb_q == DIR_UP) begin
						state_q <= S_DEQ;
					end else begin
						nb_q <= dir_t'(nb_q + 2'd1);
					end
				end
				S_NB_WR: begin
					if (nb_new) begin
						tail_q <= tail_q + (AW + 1)'(1);
					end
					if (nb_q == DIR_UP) begin
						state_q <= S_DEQ;
					end else begin
						nb_q    <= dir_t'(nb_q + 2'd1);
						state_q <= S_NB_RD;
					end
				end
				S_RESULT: begin
					if (out_free) begin
						clr_addr_q <= '0;
						state_q    <= wrap_q ? S_CLEAR : S_IDLE;
					end
				end
				default: begin
					state_q <= S_CLEAR;
				end
			endcase
		end
	end

	assign ready     = state_q == S_IDLE;
	assign res.valid = state_q == S_RESULT;
	assign res.value = res_value_q;

	nnps_ram #(.WIDTH(PIXEL_BITS), .DEPTH(DEPTH)) u_pixel_ram (
		.clk   (clk),
		.we    (pix_we),
		.waddr (pix_waddr),
		.wdata (pix_wdata),
		.raddr (pix_raddr),
		.rdata (pix_rdata)
	);

	nnps_ram #(.WIDTH(EB), .DEPTH(DEPTH)) u_visited_ram (
		.clk   (clk),
		.we    (vis_we),
		.waddr (vis_waddr),
		.wdata (vis_wdata),
		.raddr (nb_addr),
		.rdata (vis_rdata)
	);

	nnps_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_queue_ram (
		.clk   (clk),
		.we    (q_we),
		.waddr (q_waddr),
		.wdata (q_wdata),
		.raddr (head_q[AW-1:0]),
		.rdata (q_rdata)
	);

endmodule

// File: rtl/nearest_nonzero_pixel_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_nonzero_pixel_search
// Disparity image store with a breadth-first search for the nearest nonzero
// pixel around a queried position.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake            word contents
//  --------  ---  -------------------  ------------------------------------
//  item      in   valid/ready          command, column, row, pixel_value
//  result    out  valid/ready          nearest_value (one word per query)
//  cfg       in   cfg_write (no wait)  cfg_index, cfg_data (width, height)
//
//  A write word leaves the block in S_IDLE, ready for the next word.
//  A query outside the image goes straight to S_RESULT, one on a nonzero
//  start pixel via S_START; the output register takes the result word as
//  the engine leaves S_RESULT. A search steps through S_DEQ, S_DEQ_WAIT
//  and S_PIX per dequeued pixel, plus S_NB_RD and S_NB_WR per in-image
//  neighbour (S_NB_RD alone off the image), bound by the single read port
//  of the visited map and of the coordinate queue. After reset, and after
//  every 255th search that reaches the queue, a clearing pass writes each of
//  the 2**(clog2(MAX_WIDTH)+clog2(MAX_HEIGHT)) visited map entries once,
//  65536 with default sizes; no item is taken meanwhile. A stalled result
//  is held in the output register; the engine may search meanwhile, but
//  holds its next answer in S_RESULT and then accepts no new word.
module nearest_nonzero_pixel_search #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256,
	parameter int PIXEL_BITS = 8
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	nnps_in_if.sink                              item,
	nnps_out_if.source                           result,
	input  logic                                 cfg_write,
	input  logic [nnps_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [nnps_pkg::CFG_BITS-1:0]        cfg_data
);

	nnps_pkg::cfg_t  cfg_q;
	nnps_pkg::item_t item_word;
	nnps_pkg::res_t  eng_res;
	logic            eng_ready;
	logic            start;
	logic            out_free;
	logic            out_valid_q;
	logic [nnps_pkg::VALUE_BITS-1:0] out_value_q;

	// configuration registers: hold the image size in use
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_width  <= nnps_pkg::SIZE_RESET;
			cfg_q.image_height <= nnps_pkg::SIZE_RESET;
		end else if (cfg_write) begin
			case (nnps_pkg::reg_idx_t'(cfg_index))
				nnps_pkg::REG_WIDTH: begin
					cfg_q.image_width <= cfg_data;
				end
				nnps_pkg::REG_HEIGHT: begin
					cfg_q.image_height <= cfg_data;
				end
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	// pack the incoming word for the engine
	assign item_word.command     = nnps_pkg::cmd_t'(item.command);
	assign item_word.column      = item.column;
	assign item_word.row         = item.row;
	assign item_word.pixel_value = item.pixel_value;

	assign item.ready = eng_ready;
	assign start      = item.valid && eng_ready;

	// output register: free when empty or being drained this cycle
	assign out_free = !out_valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_value_q <= '0;
		end else if (eng_res.valid && out_free) begin
			out_valid_q <= 1'b1;
			out_value_q <= eng_res.value;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.nearest_value = out_value_q;

	nnps_engine #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.PIXEL_BITS (PIXEL_BITS)
	) u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.item     (item_word),
		.cfg      (cfg_q),
		.ready    (eng_ready),
		.out_free (out_free),
		.res      (eng_res)
	);

endmodule

// File: rtl/nnps_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nnps_checker
// Port-level checks on the search block, bound to the top level.
// ----------------------------------------------------------------------------
module nnps_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            item_valid,
	input logic                            item_ready,
	input logic                            item_command,
	input logic                            result_valid,
	input logic                            result_ready,
	input logic [nnps_pkg::VALUE_BITS-1:0] nearest_value
);

	// a stalled result word holds
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(nearest_value))
	else $error("stalled result word changed");

	// ready is low in the cycle after a query is taken
	assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && (item_command == nnps_pkg::CMD_QUERY) |=> !item_ready)
	else $error("ready stayed high after a query");

	// a pixel write leaves the block ready
	assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && (item_command == nnps_pkg::CMD_WRITE) |=> item_ready)
	else $error("ready dropped after a pixel write");

	// a new result word only comes out of a busy engine
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> !$past(item_ready))
	else $error("result appeared while the engine was idle");

endmodule

bind nearest_nonzero_pixel_search nnps_checker u_nnps_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.item_valid    (item.valid),
	.item_ready    (item.ready),
	.item_command  (item.command),
	.result_valid  (result.valid),
	.result_ready  (result.ready),
	.nearest_value (result.nearest_value)
);
